>>> hw/rtl/rbst_pkg.sv
`timescale 1ns / 1ps
package rbst_pkg;

	localparam int NUM_REGS = 7;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MAX_X = 3'd1,
		REG_MIN_Y = 3'd2,
		REG_MAX_Y = 3'd3,
		REG_MIN_Z = 3'd4,
		REG_MAX_Z = 3'd5,
		REG_UNBND = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic       valid;
		logic       unbnd;
		logic       miss;
		logic [2:0] zero;
	} ctl_t;

endpackage

>>> hw/rtl/rbst_div.sv
`timescale 1ns / 1ps
module rbst_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W:0]   num,
	input  logic signed [W-1:0] den,
	output logic signed [W-1:0] quo
);
	localparam int NW    = W + 1 + F;
	localparam int STEPS = W + 1;
	localparam logic [W:0]   LIM     = {2'b01, {(W-1){1'b0}}};
	localparam logic [W:0]   LIM_M1  = LIM - 1'b1;
	localparam logic [W-1:0] SAT_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SAT_NEG = {1'b1, {(W-1){1'b0}}};

	logic          neg_c;
	logic [W:0]    an_c;
	logic [W-1:0]  ad_c;
	logic [NW-1:0] nfull_c;
	logic          ovf_c;

	logic [W-1:0] rem_s [0:STEPS];
	logic [W:0]   low_s [0:STEPS];
	logic [W:0]   q_s   [0:STEPS];
	logic [W-1:0] ad_s  [0:STEPS];
	logic         neg_s [0:STEPS];
	logic         ovf_s [0:STEPS];

	logic [W:0]   r2_c  [0:STEPS-1];
	logic         ge_c  [0:STEPS-1];

	always_comb begin
		neg_c   = num[W] ^ den[W-1];
		an_c    = num[W] ? (W+1)'(-num) : (W+1)'(num);
		ad_c    = den[W-1] ? W'(-den) : W'(den);
		nfull_c = NW'(an_c) << F;
		ovf_c   = (nfull_c >> (W + 1)) >= NW'(ad_c);
		for (int k = 0; k < STEPS; k++) begin
			r2_c[k] = {rem_s[k], low_s[k][W]};
			ge_c[k] = r2_c[k] >= {1'b0, ad_s[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= W'(nfull_c >> (W + 1));
			low_s[0] <= (W+1)'(nfull_c);
			q_s[0]   <= '0;
			ad_s[0]  <= ad_c;
			neg_s[0] <= neg_c;
			ovf_s[0] <= ovf_c;
			for (int k = 0; k < STEPS; k++) begin
				rem_s[k+1] <= ge_c[k] ? W'(r2_c[k] - {1'b0, ad_s[k]}) : W'(r2_c[k]);
				low_s[k+1] <= low_s[k] << 1;
				q_s[k+1]   <= {q_s[k][W-1:0], ge_c[k]};
				ad_s[k+1]  <= ad_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
			if (neg_s[STEPS]) begin
				if (ovf_s[STEPS] || q_s[STEPS] > LIM) begin
					quo <= SAT_NEG;
				end else begin
					quo <= W'(-q_s[STEPS]);
				end
			end else begin
				if (ovf_s[STEPS] || q_s[STEPS] > LIM_M1) begin
					quo <= SAT_POS;
				end else begin
					quo <= W'(q_s[STEPS]);
				end
			end
		end
	end

endmodule

>>> hw/rtl/rbst_front.sv
`timescale 1ns / 1ps
module rbst_front #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic signed [W-1:0] org [3],
	input  logic signed [W-1:0] dir [3],
	input  logic signed [W-1:0] box_lo [3],
	input  logic signed [W-1:0] box_hi [3],
	input  logic                unbnd,
	output rbst_pkg::ctl_t      ctl,
	output logic signed [W-1:0] t_lo [3],
	output logic signed [W-1:0] t_hi [3]
);
	import rbst_pkg::*;

	localparam int DL = W + 3;

	logic signed [W:0]   num_lo_s1 [3];
	logic signed [W:0]   num_hi_s1 [3];
	logic signed [W-1:0] dir_s1    [3];
	ctl_t                ctl_s1;
	ctl_t                sb_s [0:DL-1];
	logic [2:0]          zero_c;
	logic [2:0]          outside_c;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			zero_c[a]    = dir[a] == '0;
			outside_c[a] = (org[a] < box_lo[a]) || (org[a] > box_hi[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				num_lo_s1[a] <= {box_lo[a][W-1], box_lo[a]} - {org[a][W-1], org[a]};
				num_hi_s1[a] <= {box_hi[a][W-1], box_hi[a]} - {org[a][W-1], org[a]};
				dir_s1[a]    <= dir[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			for (int k = 0; k < DL; k++) begin
				sb_s[k] <= '0;
			end
		end else if (adv) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.unbnd <= unbnd;
			ctl_s1.miss  <= |(zero_c & outside_c);
			ctl_s1.zero  <= zero_c;
			sb_s[0] <= ctl_s1;
			for (int k = 1; k < DL; k++) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		rbst_div #(.W(W), .F(F)) u_div_lo (
			.clk (clk),
			.en  (adv),
			.num (num_lo_s1[a]),
			.den (dir_s1[a]),
			.quo (t_lo[a])
		);
		rbst_div #(.W(W), .F(F)) u_div_hi (
			.clk (clk),
			.en  (adv),
			.num (num_hi_s1[a]),
			.den (dir_s1[a]),
			.quo (t_hi[a])
		);
	end

	assign ctl = sb_s[DL-1];

endmodule

>>> hw/rtl/rbst_back.sv
`timescale 1ns / 1ps
module rbst_back #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rbst_pkg::ctl_t      ctl,
	input  logic signed [W-1:0] t_lo [3],
	input  logic signed [W-1:0] t_hi [3],
	input  logic                out_stall,
	output logic                adv,
	output logic                out_valid,
	output logic                hit
);
	import rbst_pkg::*;

	localparam int EW  = W + 2;
	localparam int QD  = 4;
	localparam int QAW = 2;
	localparam logic signed [EW-1:0] NEG_INF = {2'b11, {W{1'b0}}};
	localparam logic signed [EW-1:0] POS_INF = {2'b01, {W{1'b0}}};

	logic signed [EW-1:0] ent_s1 [3];
	logic signed [EW-1:0] ext_s1 [3];
	logic signed [EW-1:0] enter_s2;
	logic signed [EW-1:0] leave_s2;
	ctl_t                 ctl_s1;
	ctl_t                 ctl_s2;
	logic signed [EW-1:0] mx_c;
	logic signed [EW-1:0] mn_c;
	logic                 hit_c;
	logic                 push;
	logic                 pop;
	logic                 full;

	logic           mem_q [QD];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	always_comb begin
		mx_c = ent_s1[0];
		mn_c = ext_s1[0];
		for (int a = 1; a < 3; a++) begin
			if (ent_s1[a] > mx_c) begin
				mx_c = ent_s1[a];
			end
			if (ext_s1[a] < mn_c) begin
				mn_c = ext_s1[a];
			end
		end
		hit_c = ctl_s2.unbnd || (!ctl_s2.miss && leave_s2 >= enter_s2);
	end

	assign full      = cnt_q == (QAW+1)'(QD);
	assign adv       = !(full && ctl_s2.valid);
	assign push      = adv && ctl_s2.valid;
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && !out_stall;
	assign hit       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				if (ctl.zero[a]) begin
					ent_s1[a] <= NEG_INF;
					ext_s1[a] <= POS_INF;
				end else if (t_lo[a] > t_hi[a]) begin
					ent_s1[a] <= EW'(t_hi[a]);
					ext_s1[a] <= EW'(t_lo[a]);
				end else begin
					ent_s1[a] <= EW'(t_lo[a]);
					ext_s1[a] <= EW'(t_hi[a]);
				end
			end
			enter_s2 <= mx_c;
			leave_s2 <= mn_c;
		end
		if (push) begin
			mem_q[wr_ptr_q] <= hit_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (adv) begin
				ctl_s1 <= ctl;
				ctl_s2 <= ctl_s1;
			end
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/ray_box_slab_test.sv
`timescale 1ns / 1ps
// channel | valid    | stall     | beat
// in      | in_valid | in_stall  | origin_x/y/z, dir_x/y/z
// out     | out_valid| out_stall | hit
// cfg     | cfg_we   | (none)    | cfg_index, cfg_data
// One ray is taken per cycle while in_stall is low; six pipelined dividers, one quotient bit per
// stage, set the depth from a ray beat to its result.
// Reset clears configuration to zero and empties the pipeline and the four-entry result queue.
// A stalled output only stops the front once the queue is full and a result is ready to enter it.
module ray_box_slab_test #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [WORD_BITS-1:0] origin_x,
	input  logic signed [WORD_BITS-1:0] origin_y,
	input  logic signed [WORD_BITS-1:0] origin_z,
	input  logic signed [WORD_BITS-1:0] dir_x,
	input  logic signed [WORD_BITS-1:0] dir_y,
	input  logic signed [WORD_BITS-1:0] dir_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [WORD_BITS-1:0]        cfg_data
);
	import rbst_pkg::*;

	localparam int W = WORD_BITS;

	logic signed [W-1:0] box_lo_q [3];
	logic signed [W-1:0] box_hi_q [3];
	logic                unbnd_q;
	logic signed [W-1:0] org [3];
	logic signed [W-1:0] dir [3];
	logic signed [W-1:0] t_lo [3];
	logic signed [W-1:0] t_hi [3];
	ctl_t                ctl;
	logic                adv;

	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_lo_q[a] <= '0;
				box_hi_q[a] <= '0;
			end
			unbnd_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MIN_X: box_lo_q[0] <= cfg_data;
				REG_MAX_X: box_hi_q[0] <= cfg_data;
				REG_MIN_Y: box_lo_q[1] <= cfg_data;
				REG_MAX_Y: box_hi_q[1] <= cfg_data;
				REG_MIN_Z: box_lo_q[2] <= cfg_data;
				REG_MAX_Z: box_hi_q[2] <= cfg_data;
				REG_UNBND: unbnd_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rbst_front #(.W(W), .F(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.org      (org),
		.dir      (dir),
		.box_lo   (box_lo_q),
		.box_hi   (box_hi_q),
		.unbnd    (unbnd_q),
		.ctl      (ctl),
		.t_lo     (t_lo),
		.t_hi     (t_hi)
	);

	rbst_back #(.W(W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.t_lo      (t_lo),
		.t_hi      (t_hi),
		.out_stall (out_stall),
		.adv       (adv),
		.out_valid (out_valid),
		.hit       (hit)
	);

endmodule

>>> hw/rtl/rbst_checker.sv
`timescale 1ns / 1ps
module rbst_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic hit
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit))
		else $error("result beat changed under stall");

	a_empty_ready: assert property (@(posedge clk)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result queue");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result beat right after reset");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import rbst_pkg::*;

	localparam int WB = 32;
	localparam int FB = 16;
	localparam int LAT = WB + 7;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [WB-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [WB-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [WB-1:0] cfg_data = '0;

	typedef struct {
		logic signed [WB-1:0] o [3];
		logic signed [WB-1:0] d [3];
		logic known;
		logic want;
	} ray_t;

	logic signed [WB-1:0] box_lo [3];
	logic signed [WB-1:0] box_hi [3];
	logic box_unbnd;
	logic hit_q [$];
	int mismatches = 0;
	int seen = 0;
	bit feeding_done = 0;
	bit hold_long = 0;

	always #10 clk = ~clk;

	ray_box_slab_test #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_top (.*);

	function automatic longint slab_div(longint num, longint den);
		bit neg;
		longint an, ad, q, lim, mag;
		neg = (num < 0) != (den < 0);
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		lim = 64'sd1 <<< (WB - 1);
		q = an / ad;
		if (q > (lim >>> FB))
			return neg ? -lim : lim - 1;
		mag = (an <<< FB) / ad;
		if (neg) begin
			if (mag > lim) mag = lim;
			return -mag;
		end
		if (mag > lim - 1) mag = lim - 1;
		return mag;
	endfunction

	function automatic logic ray_hits(ray_t r);
		longint enter, leave, t0, t1, s, org, dir, lo, hi;
		bit miss;
		enter = -(64'sd1 <<< WB);
		leave = 64'sd1 <<< WB;
		miss = 0;
		if (box_unbnd) return 1'b1;
		for (int a = 0; a < 3; a++) begin
			org = r.o[a];
			dir = r.d[a];
			lo = box_lo[a];
			hi = box_hi[a];
			if (dir == 0) begin
				if (org < lo || org > hi) miss = 1;
			end else begin
				t0 = slab_div(lo - org, dir);
				t1 = slab_div(hi - org, dir);
				if (t0 > t1) begin
					s = t0; t0 = t1; t1 = s;
				end
				if (t0 > enter) enter = t0;
				if (t1 < leave) leave = t1;
			end
		end
		return (!miss && leave >= enter);
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [WB-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_X: box_lo[0] = val;
			REG_MAX_X: box_hi[0] = val;
			REG_MIN_Y: box_lo[1] = val;
			REG_MAX_Y: box_hi[1] = val;
			REG_MIN_Z: box_lo[2] = val;
			REG_MAX_Z: box_hi[2] = val;
			default: box_unbnd = val[0];
		endcase
	endtask

	task automatic set_box(logic [WB-1:0] v [6], logic u);
		in_valid <= 1'b0;
		wait (hit_q.size() == 0);
		repeat (LAT + 4) @(posedge clk);
		write_reg(REG_MIN_X, v[0]);
		write_reg(REG_MAX_X, v[1]);
		write_reg(REG_MIN_Y, v[2]);
		write_reg(REG_MAX_Y, v[3]);
		write_reg(REG_MIN_Z, v[4]);
		write_reg(REG_MAX_Z, v[5]);
		write_reg(REG_UNBND, {31'd0, u});
	endtask

	task automatic send_ray(ray_t r);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		origin_x <= r.o[0]; origin_y <= r.o[1]; origin_z <= r.o[2];
		dir_x <= r.d[0]; dir_y <= r.d[1]; dir_z <= r.d[2];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		hit_q.push_back(r.known ? r.want : ray_hits(r));
	endtask

	function automatic logic signed [WB-1:0] rnd_word(int mode);
		logic signed [WB-1:0] w;
		case (mode)
			0: w = $urandom;
			1: w = $signed($urandom_range(0, 20 << FB)) - (10 << FB);
			2: w = $signed($urandom_range(0, 200)) - 100;
			3: w = '0;
			4: w = {1'b1, {(WB-1){1'b0}}};
			default: w = {1'b0, {(WB-1){1'b1}}};
		endcase
		return w;
	endfunction

	function automatic ray_t rnd_ray();
		ray_t r;
		int m;
		m = $urandom_range(0, 9);
		for (int a = 0; a < 3; a++) begin
			r.o[a] = rnd_word(m < 5 ? 1 : (m < 7 ? 0 : $urandom_range(0, 5)));
			r.d[a] = rnd_word($urandom_range(0, 5) == 0 ? 3 :
				(m < 5 ? ($urandom_range(0, 1) ? 1 : 2) : $urandom_range(0, 5)));
		end
		r.known = 0;
		r.want = 0;
		return r;
	endfunction

	localparam logic [WB-1:0] MINW = {1'b1, {(WB-1){1'b0}}};
	localparam logic [WB-1:0] MAXW = {1'b0, {(WB-1){1'b1}}};
	localparam logic [WB-1:0] ONE = 1 << FB;
	localparam logic [WB-1:0] NONE = -(1 << FB);

	// origin, direction, whether the answer is typed in, the answer
	typedef struct {
		logic [WB-1:0] o;
		logic [WB-1:0] d;
		logic known;
		logic want;
	} row_t;

	initial begin
		logic [WB-1:0] bx [6];
		row_t rows [16];
		ray_t r;
		arst_n <= 1'b0;
		for (int a = 0; a < 3; a++) begin
			box_lo[a] = '0; box_hi[a] = '0;
		end
		box_unbnd = 0;
		rows = '{
			'{'0, '0, 1, 1}, '{ONE, '0, 1, 0}, '{MINW, '0, 1, 0}, '{MAXW, '0, 1, 0},
			'{NONE, ONE, 0, 0}, '{ONE, NONE, 0, 0}, '{MINW, MAXW, 0, 0},
			'{MAXW, MINW, 0, 0}, '{MINW, MINW, 0, 0}, '{MAXW, MAXW, 0, 0},
			'{'0, 32'd1, 0, 0}, '{'0, 32'hFFFFFFFF, 0, 0}, '{32'h00008000, ONE, 0, 0},
			'{NONE, 32'd3, 0, 0}, '{ONE, 32'h7, 0, 0}, '{'0, MINW, 0, 0}};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// reset box is a single point at the origin
		foreach (rows[i]) begin
			for (int a = 0; a < 3; a++) begin
				r.o[a] = a == 0 ? rows[i].o : '0;
				r.d[a] = a == 0 ? rows[i].d : '0;
			end
			r.known = rows[i].known;
			r.want = rows[i].want;
			send_ray(r);
		end
		bx = '{NONE, ONE, NONE, ONE, NONE, ONE};
		set_box(bx, 0);
		foreach (rows[i]) begin
			for (int a = 0; a < 3; a++) begin
				r.o[a] = rows[(i + a) % 16].o;
				r.d[a] = rows[(i + 2 * a) % 16].d;
			end
			r.known = 0;
			send_ray(r);
		end
		bx = '{MINW, MAXW, MINW, MAXW, MINW, MAXW};
		set_box(bx, 1);
		for (int i = 0; i < 4; i++) begin
			r = rnd_ray();
			r.known = 1;
			r.want = 1;
			send_ray(r);
		end
		for (int ph = 0; ph < 6; ph++) begin
			for (int k = 0; k < 6; k += 2) begin
				if (ph == 1) begin
					bx[k] = MINW; bx[k+1] = MAXW;
				end else if (ph == 2) begin
					bx[k] = MAXW; bx[k+1] = MINW;
				end else if (ph == 0) begin
					bx[k] = rnd_word(1); bx[k+1] = bx[k] + $urandom_range(0, 8 << FB);
				end else begin
					bx[k] = rnd_word(ph == 5 ? 0 : 1);
					bx[k+1] = rnd_word(ph == 5 ? 0 : 1);
				end
			end
			set_box(bx, ph == 4 ? $urandom_range(0, 1) : 0);
			if (ph == 3) hold_long = 1;
			for (int i = 0; i < 250; i++) begin
				r = rnd_ray();
				if (ph < 3 && $urandom_range(0, 1)) begin
					for (int a = 0; a < 3; a++)
						r.o[a] = box_lo[a] + $urandom_range(0, 3);
				end
				send_ray(r);
			end
		end
		in_valid <= 1'b0;
		feeding_done = 1;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				hold_long = 0;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end
			gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
			if ($urandom_range(0, 4) == 0) gap = 0;
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (hit_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat: hit=%0b", hit);
			end else begin
				if (hit !== hit_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: hit expected %0b got %0b", seen, hit_q[0], hit);
				end
				void'(hit_q.pop_front());
			end
			seen++;
		end
	end

	initial begin
		wait (feeding_done);
		wait (hit_q.size() == 0);
		repeat (LAT + 20) @(posedge clk);
		if (mismatches == 0 && hit_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#(20 * 400000);
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/rbst_pkg.sv
hw/rtl/rbst_div.sv
hw/rtl/rbst_front.sv
hw/rtl/rbst_back.sv
hw/rtl/ray_box_slab_test.sv
hw/rtl/rbst_checker.sv
test/testbench.sv
